FILE: design/pwlcq_pkg.sv
package pwlcq_pkg;

  localparam int POINTS = 64;
  localparam int IDX_W  = 6;   // table address bits
  localparam int N_W    = 7;   // point count, holds POINTS itself

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_CDF    = 2'd1;
  localparam logic [1:0] OP_QUANT  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;  // no effect, returns zero

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDIV = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam int DIV_STEPS = 32;  // two quotient bits per step, 64-bit dividend

  typedef struct packed {
    logic start;     // input word accepted
    logic probe;     // search: check end, issue probe read
    logic cmp;       // search: compare probe key
    logic rda;       // read lower interval point
    logic rdb;       // read upper interval point
    logic setup;     // form operands, detect early exits
    logic mul;       // multiply magnitudes into divider
    logic div_step;  // one divider step
    logic fin;       // sign, add base, saturate
    logic out_load;  // move result into output register
  } cmd_t;

  typedef struct packed {
    logic search_end;
    logic early;
    logic div_last;
    logic out_free;
  } stat_t;

endpackage

FILE: design/pwlcq_ctrl.sv
module pwlcq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic [1:0]          s_tuser,
  output logic                s_tready,
  input  pwlcq_pkg::stat_t    stat,
  output pwlcq_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_PROBE, S_CMP, S_RDA, S_RDB, S_SETUP, S_MUL, S_DIV, S_FIN, S_OUT
  } state_t;

  state_t state;

  always_comb begin
    cmd          = '0;
    s_tready     = (state == S_IDLE);
    cmd.start    = (state == S_IDLE) && s_tvalid;
    cmd.probe    = (state == S_PROBE);
    cmd.cmp      = (state == S_CMP);
    cmd.rda      = (state == S_RDA);
    cmd.rdb      = (state == S_RDB);
    cmd.setup    = (state == S_SETUP);
    cmd.mul      = (state == S_MUL);
    cmd.div_step = (state == S_DIV);
    cmd.fin      = (state == S_FIN);
    cmd.out_load = (state == S_OUT) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser == pwlcq_pkg::OP_CDF || s_tuser == pwlcq_pkg::OP_QUANT) begin
              state <= S_PROBE;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_PROBE: state <= stat.search_end ? S_RDA : S_CMP;
        S_CMP:   state <= S_PROBE;
        S_RDA:   state <= S_RDB;
        S_RDB:   state <= S_SETUP;
        S_SETUP: state <= stat.early ? S_OUT : S_MUL;
        S_MUL:   state <= S_DIV;
        S_DIV: begin
          if (stat.div_last) begin
            state <= S_FIN;
          end
        end
        S_FIN:   state <= S_OUT;
        S_OUT: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/pwlcq_datapath.sv
module pwlcq_datapath (
  input  logic                clk,
  input  logic                rst,
  input  pwlcq_pkg::cmd_t     cmd,
  output pwlcq_pkg::stat_t    stat,
  input  logic [1:0]          s_tuser,
  input  logic [87:0]         s_tdata,
  input  logic                cfg_valid,
  input  logic [6:0]          cfg_data,
  input  logic                m_tready,
  output logic                m_tvalid,
  output logic [39:0]         m_tdata
);

  localparam int IW = pwlcq_pkg::IDX_W;
  localparam int NW = pwlcq_pkg::N_W;

  // table memories, one read port each, registered read
  logic signed [31:0] xmem [pwlcq_pkg::POINTS];
  logic        [16:0] fmem [pwlcq_pkg::POINTS];
  logic signed [31:0] rd_x;
  logic        [16:0] rd_f;
  logic [IW-1:0]      raddr;

  logic [NW-1:0] num_points;
  logic [NW-1:0] n;
  logic signed [31:0] v;

  // search
  logic signed [7:0] lo, hi, mid, mn, mx;
  logic              found;
  logic [IW-1:0]     sidx;
  logic              is_q;

  // operands, magnitudes up to 33 bits
  logic signed [31:0] xa;
  logic        [16:0] fa;
  logic [32:0]        ma, mb, md;
  logic               neg;
  logic signed [33:0] base;

  // divider
  logic [63:0] quot;
  logic [32:0] rem;
  logic [4:0]  cnt;

  logic signed [31:0] res;
  logic [1:0]         st;

  // ---------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      num_points <= NW'(2);
    end else if (cfg_valid) begin
      num_points <= cfg_data;
    end
  end

  always_comb begin
    if (num_points < NW'(2)) begin
      n = NW'(2);
    end else if (num_points > NW'(pwlcq_pkg::POINTS)) begin
      n = NW'(pwlcq_pkg::POINTS);
    end else begin
      n = num_points;
    end
  end

  // ---------------- search logic
  logic              send;
  logic signed [8:0] lohi;
  logic signed [7:0] mid_new;
  logic signed [7:0] mclamp;
  logic signed [32:0] key, v33;
  logic signed [7:0] nm1;

  assign send    = found || (lo == hi);
  assign lohi    = 9'(lo) + 9'(hi);
  assign mid_new = 8'(lohi >>> 1);
  assign nm1     = 8'(n) - 8'sd1;
  assign key     = is_q ? $signed({16'b0, rd_f}) : 33'(rd_x);
  assign v33     = 33'(v);

  always_comb begin
    mclamp = mid;
    if (mid < mn) begin
      mclamp = mn;
    end else if (mid > mx) begin
      mclamp = mx;
    end
    if (is_q && mclamp > nm1) begin
      mclamp = nm1;
    end
  end

  logic [IW-1:0] addr_a, addr_b;
  logic          first_pt;
  assign first_pt = is_q && (sidx == '0);
  assign addr_a   = first_pt ? '0 : sidx - IW'(1);
  assign addr_b   = first_pt ? IW'(nm1) : sidx;

  always_comb begin
    raddr = mid_new[IW-1:0];
    if (cmd.rda) begin
      raddr = addr_a;
    end else if (cmd.rdb) begin
      raddr = addr_b;
    end
  end

  logic [IW-1:0] widx;
  assign widx = s_tdata[5:0];

  always_ff @(posedge clk) begin
    if (cmd.start && s_tuser == pwlcq_pkg::OP_LOAD) begin
      xmem[widx] <= s_tdata[37:6];
      fmem[widx] <= s_tdata[54:38];
    end
    rd_x <= xmem[raddr];
    rd_f <= fmem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      v     <= s_tdata[86:55];
      is_q  <= (s_tuser == pwlcq_pkg::OP_QUANT);
      found <= 1'b0;
      mid   <= '0;
      if (s_tuser == pwlcq_pkg::OP_QUANT) begin
        lo <= 8'sd0;  hi <= 8'(n);
        mn <= 8'sd0;  mx <= 8'(n);
      end else begin
        lo <= 8'sd1;  hi <= nm1;
        mn <= 8'sd1;  mx <= nm1;
      end
    end
    if (cmd.probe) begin
      if (send) begin
        sidx <= mclamp[IW-1:0];
      end else begin
        mid <= mid_new;
      end
    end
    if (cmd.cmp) begin
      if (v33 == key) begin
        found <= 1'b1;
      end else if (hi - lo > 8'sd1) begin
        if (v33 > key) lo <= mid; else hi <= mid;
      end else if (v33 > key) begin
        mid <= mid + 8'sd1;
        lo  <= hi;
      end else begin
        mid <= mid - 8'sd1;
        hi  <= lo;
      end
    end
  end

  // ---------------- operand setup
  logic signed [33:0] sxa, sxb, sfa, sfb, sv, a, b, d, sbase, abs_a, abs_b, abs_d;
  logic               above, zero, early;
  logic signed [31:0] early_val;

  assign sxa = 34'(xa);
  assign sxb = 34'(rd_x);
  assign sfa = $signed({17'b0, fa});
  assign sfb = $signed({17'b0, rd_f});
  assign sv  = 34'(v);

  always_comb begin
    if (rd_x > 32'sd0) begin
      above = xa > rd_x;
    end else if (rd_x < 32'sd0) begin
      above = xa < rd_x;
    end else begin
      above = xa > 32'sd0;
    end
    if (!is_q) begin
      a = sv - sxa;  b = sfb - sfa;  d = sxb - sxa;  sbase = sfa;
      early_val = $signed({15'b0, fa});
    end else if (!first_pt) begin
      a = sv - sfa;  b = sxb - sxa;  d = sfb - sfa;  sbase = sxa;
      early_val = xa;
    end else begin
      a = sv;  b = sxa;  d = sfa;  sbase = '0;
      early_val = xa;
    end
    zero  = (d == '0);
    early = zero || (first_pt && !above);
    abs_a = a[33] ? -a : a;
    abs_b = b[33] ? -b : b;
    abs_d = d[33] ? -d : d;
  end

  // ---------------- divider step, two bits
  logic [33:0] r1, r2;
  logic [32:0] rem1, rem2;
  logic        q1, q2;

  always_comb begin
    r1   = {rem, quot[63]};
    q1   = (r1 >= {1'b0, md});
    rem1 = q1 ? 33'(r1 - {1'b0, md}) : r1[32:0];
    r2   = {rem1, quot[62]};
    q2   = (r2 >= {1'b0, md});
    rem2 = q2 ? 33'(r2 - {1'b0, md}) : r2[32:0];
  end

  // ---------------- final sign, add and saturate
  logic               big;
  logic signed [35:0] q36, s36;
  logic signed [31:0] fin_val;
  logic [1:0]         fin_st;

  always_comb begin
    big = quot > 64'h2_0000_0000;
    q36 = $signed({2'b00, quot[33:0]});
    s36 = 36'(base) + (neg ? -q36 : q36);
    fin_st = pwlcq_pkg::ST_OK;
    fin_val = s36[31:0];
    if (big) begin
      fin_st  = pwlcq_pkg::ST_SAT;
      fin_val = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (s36 > 36'sd2147483647) begin
      fin_st  = pwlcq_pkg::ST_SAT;
      fin_val = 32'sh7FFF_FFFF;
    end else if (s36 < -36'sd2147483648) begin
      fin_st  = pwlcq_pkg::ST_SAT;
      fin_val = 32'sh8000_0000;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rdb) begin
      xa <= rd_x;
      fa <= rd_f;
    end
    if (cmd.setup) begin
      ma   <= abs_a[32:0];
      mb   <= abs_b[32:0];
      md   <= abs_d[32:0];
      neg  <= a[33] ^ b[33] ^ d[33];
      base <= sbase;
    end
    if (cmd.mul) begin
      // product kept modulo 2^64
      quot <= {31'b0, ma} * {31'b0, mb};
      rem  <= '0;
      cnt  <= '0;
    end
    if (cmd.div_step) begin
      quot <= {quot[61:0], q1, q2};
      rem  <= rem2;
      cnt  <= cnt + 5'd1;
    end
    if (cmd.start) begin
      res <= '0;
      st  <= pwlcq_pkg::ST_OK;
    end
    if (cmd.setup && early) begin
      res <= early_val;
      // first point at or below the ratio limit returns x0 without a division
      st  <= (first_pt && !above) ? pwlcq_pkg::ST_OK : pwlcq_pkg::ST_ZDIV;
    end
    if (cmd.fin) begin
      res <= fin_val;
      st  <= fin_st;
    end
  end

  // ---------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {6'b0, st, res};
    end
  end

  assign stat.search_end = send;
  assign stat.early      = early;
  assign stat.div_last   = (cnt == 5'(pwlcq_pkg::DIV_STEPS - 1));
  assign stat.out_free   = !m_tvalid || m_tready;

endmodule

FILE: design/piecewise_linear_cdf_quantile.sv
// Piecewise-linear CDF / quantile engine.
// Input stream (s_*): one word per operation. s_tuser is the opcode:
//   load point, CDF at x, or quantile at p. A load writes one table slot.
// Config channel (cfg_*): num_points, always ready; write only while idle.
//   Values below 2 act as 2, above 64 as 64. Reset value is 2.
// Output stream (m_*): exactly one result word per input word, in order:
//   interpolated value (Q16.16) and status (ok, zero divisor, saturated).
// One word is worked on at a time; s_tready is high only when idle.
// Sequence: a load or unused opcode goes straight to the output. A query
//   runs binary-search probes (registered table read, then compare), fetches
//   both interval points and forms operands, does one 33x33 multiply, runs a
//   radix-4 restoring divider, then signs, adds and saturates. Zero-divisor
//   cases and first-point quantile cases with the above flag clear skip the
//   multiply and divide.
// Results sit in an output register; a stalled m_tready holds the word,
//   and the next input word is still taken while it waits.
// Reset clears control state and sets num_points to 2; table contents are
//   undefined until loaded.
module piecewise_linear_cdf_quantile (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // point_index[5:0], point_x[37:6], point_f[54:38],
                                 // query_value[86:55]
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // result_value[31:0], status[33:32]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data   // num_points
);

  pwlcq_pkg::cmd_t  cmd;
  pwlcq_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  pwlcq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pwlcq_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata)
  );

endmodule

FILE: design/pwlcq_checker.sv
module pwlcq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // one word in flight: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while busy");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[33:32] <= pwlcq_pkg::ST_SAT)
    else $error("bad status code");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

endmodule

bind piecewise_linear_cdf_quantile pwlcq_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
